### sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared types, constants and helpers of the decimal time clock
// Register codes, seven-segment table, BCD pair increment and the scan
// control bundle passed from the phase accumulator to the time core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtc_pkg;

  localparam int unsigned INC_W   = 16;
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned COUNT_W = 7;

  localparam logic [INC_W-1:0] INC_RESET = 16'd256;
  localparam logic [ACC_W-1:0] MOD_RESET = 17'd86400;
  localparam logic [THR_W-1:0] THR_RESET = 8'd10;

  localparam logic [7:0] SEG_ZERO  = 8'h7E;
  localparam logic [7:0] DP_MASK   = 8'h01;
  localparam logic [7:0] PRESS_MAX = 8'hFF;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_PHASE_MOD = 2'd1,
    CFG_PRESS_THR = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic scan;   // this base tick runs a scan step
    logic tick;   // a pending decimal tick is consumed in that step
  } scan_ctl_t;

  typedef struct packed {
    logic [3:0] units;
    logic [3:0] tens;
    logic       carry;
  } bcd_pair_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h7E;
      4'd1:    pat = 8'h18;
      4'd2:    pat = 8'hB6;
      4'd3:    pat = 8'hBC;
      4'd4:    pat = 8'hD8;
      4'd5:    pat = 8'hEC;
      4'd6:    pat = 8'hEE;
      4'd7:    pat = 8'h1C;
      4'd8:    pat = 8'hFE;
      4'd9:    pat = 8'hFC;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  // Advance a two-digit decimal pair, flag the wrap from 99 to 00.
  function automatic bcd_pair_t bump_pair(input logic [3:0] units, input logic [3:0] tens);
    bcd_pair_t r;
    r.units = units + 4'd1;
    r.tens  = tens;
    r.carry = 1'b0;
    if (r.units > DIGIT_MAX) begin
      r.units = 4'd0;
      r.tens  = tens + 4'd1;
      if (r.tens > DIGIT_MAX) begin
        r.tens  = 4'd0;
        r.carry = 1'b1;
      end
    end
    return r;
  endfunction

  // Decimal value of a pair, kept to seven bits.
  function automatic logic [COUNT_W-1:0] pair_value(input logic [3:0] units,
                                                     input logic [3:0] tens);
    logic [COUNT_W-1:0] t;
    t = {3'b000, tens};
    return (t << 3) + (t << 1) + {3'b000, units};
  endfunction

endpackage

### sv/decimal_time_clock_display_core.sv
// ----------------------------------------------------------------------------
// decimal_time_clock_display_core: decimal time clock with 4-digit display scan
// Path: an accepted item passes the input reg, then the result reg.
// Throughput: 1 item per cycle while out_ready holds; the single-pass update sits between the two.
// Reset: synchronous active-low rst_n clears counters, registers config to
// defaults (256, 86400, 10) and sets all digit patterns to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_time_clock_display_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item: one base timer tick with button levels
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_button_adv_cent,
  input  logic                        in_button_adv_int,
  // result item
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_scan_valid,
  output logic [3:0]                  out_digit_enable,
  output logic [7:0]                  out_segment_pattern,
  output logic [dtc_pkg::COUNT_W-1:0] out_interval_count,
  output logic [dtc_pkg::COUNT_W-1:0] out_centival_count,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [dtc_pkg::CFG_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [dtc_pkg::INC_W-1:0]   phase_inc_r;
  logic [dtc_pkg::ACC_W-1:0]   phase_mod_r;
  logic [dtc_pkg::THR_W-1:0]   press_thr_r;

  // Input stage.
  logic                        s1_valid_r;
  logic                        s1_cent_r;
  logic                        s1_int_r;

  // Result stage.
  logic                        out_valid_r;
  logic                        out_scan_r;
  logic [3:0]                  out_sel_r;
  logic [7:0]                  out_pat_r;
  logic [dtc_pkg::COUNT_W-1:0] out_int_r;
  logic [dtc_pkg::COUNT_W-1:0] out_cent_r;

  logic                        advance;
  dtc_pkg::scan_ctl_t          ctl;
  logic [3:0]                  core_sel;
  logic [7:0]                  core_pat;
  logic [dtc_pkg::COUNT_W-1:0] core_int;
  logic [dtc_pkg::COUNT_W-1:0] core_cent;

  // Move the staged item into the result register whenever that slot is
  // free or being emptied this cycle; the input stage refills behind it.
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= dtc_pkg::INC_RESET;
      phase_mod_r <= dtc_pkg::MOD_RESET;
      press_thr_r <= dtc_pkg::THR_RESET;
    end else if (cfg_valid) begin
      case (dtc_pkg::cfg_index_t'(cfg_index))
        dtc_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_data[dtc_pkg::INC_W-1:0];
        dtc_pkg::CFG_PHASE_MOD: phase_mod_r <= cfg_data[dtc_pkg::ACC_W-1:0];
        dtc_pkg::CFG_PRESS_THR: press_thr_r <= cfg_data[dtc_pkg::THR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Hold the accepted item until the update pass takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cent_r <= in_button_adv_cent;
      s1_int_r  <= in_button_adv_int;
    end
  end

  // Phase accumulator and prescaler decide whether this tick scans.
  dtc_phase_accum u_phase (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (advance),
    .phase_increment (phase_inc_r),
    .phase_modulus   (phase_mod_r),
    .ctl             (ctl)
  );

  // Counters, display refresh and button timing.
  dtc_time_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (advance),
    .ctl             (ctl),
    .btn_cent        (s1_cent_r),
    .btn_int         (s1_int_r),
    .press_threshold (press_thr_r),
    .digit_enable    (core_sel),
    .segment_pattern (core_pat),
    .interval_count  (core_int),
    .centival_count  (core_cent)
  );

  // Result register: valid clears when taken unless refilled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_scan_r <= ctl.scan;
      out_sel_r  <= core_sel;
      out_pat_r  <= core_pat;
      out_int_r  <= core_int;
      out_cent_r <= core_cent;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_scan_valid      = out_scan_r;
  assign out_digit_enable    = out_sel_r;
  assign out_segment_pattern = out_pat_r;
  assign out_interval_count  = out_int_r;
  assign out_centival_count  = out_cent_r;

`ifndef ASSERT_OFF
  // A scan result selects exactly one digit.
  a_scan_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scan_r) |-> $onehot(out_sel_r))
    else $error("scan result does not select exactly one digit");

  // A non-scan result drives a blank select and pattern.
  a_idle_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_scan_r) |-> (out_sel_r == 4'd0 && out_pat_r == 8'd0))
    else $error("non-scan result carries a digit select or pattern");

  // Counters never leave the decimal range.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_int_r <= 7'd99 && out_cent_r <= 7'd99))
    else $error("decimal count out of range");

  // The input stalls only when both stages are full and the output waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule

### sv/dtc_phase_accum.sv
// ----------------------------------------------------------------------------
// dtc_phase_accum: fractional phase accumulator and scan prescaler
// Adds the increment each base tick, marks a decimal tick pending on wrap,
// and raises a scan step every 16th base tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtc_phase_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [dtc_pkg::INC_W-1:0] phase_increment,
  input  logic [dtc_pkg::ACC_W-1:0] phase_modulus,
  output dtc_pkg::scan_ctl_t        ctl
);

  logic [dtc_pkg::ACC_W-1:0] accum_r, accum_nxt;
  logic                      pending_r, pending_nxt;
  logic [3:0]                prescale_r, prescale_nxt;
  logic [dtc_pkg::ACC_W:0]   sum;
  logic [dtc_pkg::ACC_W:0]   diff;
  logic                      wrap;
  logic                      pending_set;

  always_comb begin
    sum         = {1'b0, accum_r} + {2'b00, phase_increment};
    diff        = sum - {1'b0, phase_modulus};
    wrap        = (sum >= {1'b0, phase_modulus});
    accum_nxt   = wrap ? diff[dtc_pkg::ACC_W-1:0] : sum[dtc_pkg::ACC_W-1:0];
    pending_set = pending_r | wrap;
    prescale_nxt = prescale_r + 4'd1;
    ctl.scan    = (prescale_nxt == 4'd0);
    ctl.tick    = ctl.scan & pending_set;
    pending_nxt = ctl.scan ? 1'b0 : pending_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      pending_r  <= 1'b0;
      prescale_r <= 4'd0;
    end else if (en) begin
      accum_r    <= accum_nxt;
      pending_r  <= pending_nxt;
      prescale_r <= prescale_nxt;
    end
  end

endmodule

### sv/dtc_time_core.sv
// ----------------------------------------------------------------------------
// dtc_time_core: decimal counters, display scan and button timing
// Runs one scan step per strobe: tick cascade, digit refresh, then buttons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtc_time_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  dtc_pkg::scan_ctl_t          ctl,
  input  logic                        btn_cent,
  input  logic                        btn_int,
  input  logic [dtc_pkg::THR_W-1:0]   press_threshold,
  output logic [3:0]                  digit_enable,
  output logic [7:0]                  segment_pattern,
  output logic [dtc_pkg::COUNT_W-1:0] interval_count,
  output logic [dtc_pkg::COUNT_W-1:0] centival_count
);

  logic [3:0] tick_units_r, tick_units_nxt;
  logic [3:0] tick_tens_r, tick_tens_nxt;
  logic [3:0] cent_units_r, cent_units_nxt;
  logic [3:0] cent_tens_r, cent_tens_nxt;
  logic [3:0] int_units_r, int_units_nxt;
  logic [3:0] int_tens_r, int_tens_nxt;
  logic [7:0] pat_r [4];
  logic [7:0] pat_nxt [4];
  logic [1:0] scan_idx_r, scan_idx_nxt;
  logic [7:0] press_cent_r, press_cent_nxt;
  logic [7:0] press_int_r, press_int_nxt;
  dtc_pkg::bcd_pair_t tick_b, cent_b, int_b;

  always_comb begin
    tick_units_nxt = tick_units_r;
    tick_tens_nxt  = tick_tens_r;
    cent_units_nxt = cent_units_r;
    cent_tens_nxt  = cent_tens_r;
    int_units_nxt  = int_units_r;
    int_tens_nxt   = int_tens_r;
    pat_nxt        = pat_r;
    scan_idx_nxt   = scan_idx_r;
    press_cent_nxt = press_cent_r;
    press_int_nxt  = press_int_r;
    digit_enable   = 4'd0;
    segment_pattern = 8'd0;
    tick_b = dtc_pkg::bump_pair(tick_units_r, tick_tens_r);
    cent_b = '0;
    int_b  = '0;

    if (ctl.scan) begin
      // Tick cascade: ticks, then centivals, then intervals.
      if (ctl.tick) begin
        tick_units_nxt = tick_b.units;
        tick_tens_nxt  = tick_b.tens;
        if (tick_units_r == dtc_pkg::DIGIT_MAX || tick_units_r > dtc_pkg::DIGIT_MAX) begin
          pat_nxt[1] = pat_nxt[1] ^ dtc_pkg::DP_MASK;
          pat_nxt[2] = pat_nxt[2] ^ dtc_pkg::DP_MASK;
        end
        if (tick_b.carry) begin
          cent_b = dtc_pkg::bump_pair(cent_units_nxt, cent_tens_nxt);
          cent_units_nxt = cent_b.units;
          cent_tens_nxt  = cent_b.tens;
          pat_nxt[3] = dtc_pkg::seg_pattern(cent_b.units);
          pat_nxt[2] = dtc_pkg::seg_pattern(cent_b.tens);
          if (cent_b.carry) begin
            int_b = dtc_pkg::bump_pair(int_units_nxt, int_tens_nxt);
            int_units_nxt = int_b.units;
            int_tens_nxt  = int_b.tens;
            pat_nxt[1] = dtc_pkg::seg_pattern(int_b.units);
            pat_nxt[0] = dtc_pkg::seg_pattern(int_b.tens);
          end
        end
      end

      // Display refresh sees the patterns after the cascade.
      scan_idx_nxt    = scan_idx_r + 2'd1;
      digit_enable    = 4'b0001 << scan_idx_nxt;
      segment_pattern = pat_nxt[scan_idx_nxt];

      // Centival button; no carry into intervals from here.
      if (btn_cent) begin
        if (press_cent_r > press_threshold) begin
          cent_b = dtc_pkg::bump_pair(cent_units_nxt, cent_tens_nxt);
          cent_units_nxt = cent_b.units;
          cent_tens_nxt  = cent_b.tens;
          pat_nxt[3] = dtc_pkg::seg_pattern(cent_b.units);
          pat_nxt[2] = dtc_pkg::seg_pattern(cent_b.tens);
        end
        press_cent_nxt = 8'd0;
      end else if (press_cent_r != dtc_pkg::PRESS_MAX) begin
        press_cent_nxt = press_cent_r + 8'd1;
      end

      // Interval button.
      if (btn_int) begin
        if (press_int_r > press_threshold) begin
          int_b = dtc_pkg::bump_pair(int_units_nxt, int_tens_nxt);
          int_units_nxt = int_b.units;
          int_tens_nxt  = int_b.tens;
          pat_nxt[1] = dtc_pkg::seg_pattern(int_b.units);
          pat_nxt[0] = dtc_pkg::seg_pattern(int_b.tens);
        end
        press_int_nxt = 8'd0;
      end else if (press_int_r != dtc_pkg::PRESS_MAX) begin
        press_int_nxt = press_int_r + 8'd1;
      end
    end

    interval_count = dtc_pkg::pair_value(int_units_nxt, int_tens_nxt);
    centival_count = dtc_pkg::pair_value(cent_units_nxt, cent_tens_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_units_r <= 4'd0;
      tick_tens_r  <= 4'd0;
      cent_units_r <= 4'd0;
      cent_tens_r  <= 4'd0;
      int_units_r  <= 4'd0;
      int_tens_r   <= 4'd0;
      pat_r[0]     <= dtc_pkg::SEG_ZERO;
      pat_r[1]     <= dtc_pkg::SEG_ZERO;
      pat_r[2]     <= dtc_pkg::SEG_ZERO;
      pat_r[3]     <= dtc_pkg::SEG_ZERO;
      scan_idx_r   <= 2'd0;
      press_cent_r <= 8'd0;
      press_int_r  <= 8'd0;
    end else if (en) begin
      tick_units_r <= tick_units_nxt;
      tick_tens_r  <= tick_tens_nxt;
      cent_units_r <= cent_units_nxt;
      cent_tens_r  <= cent_tens_nxt;
      int_units_r  <= int_units_nxt;
      int_tens_r   <= int_tens_nxt;
      pat_r        <= pat_nxt;
      scan_idx_r   <= scan_idx_nxt;
      press_cent_r <= press_cent_nxt;
      press_int_r  <= press_int_nxt;
    end
  end

endmodule
